### rtl/core/aob_pkg.sv
package aob_pkg;

    // Channel width; full scale FULL = 2^CB - 1 stands for 1.0.
    localparam int CB         = 8;
    // Width of a raw signed input channel.
    localparam int IW         = 10;
    localparam int LANES      = 4;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    // Quotient bits resolved per divider stage.
    localparam int BPS        = 2;
    localparam int DIV_STAGES = (CB + BPS - 1) / BPS;
    localparam int QIW        = $clog2(CB);

    // Divider operands: numerator 2N + D < 2^(3CB+1), divisor 2D < 2^(2CB+1).
    localparam int NUMW       = 3 * CB + 1;
    localparam int DENW       = 2 * CB + 1;

    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    typedef logic signed [IW-1:0]  t_raw;
    typedef logic [CB-1:0]         t_chan;
    typedef logic [2*CB-1:0]       t_prod;
    typedef logic [3*CB-1:0]       t_wide;
    typedef logic [NUMW-1:0]       t_num;
    typedef logic [DENW-1:0]       t_den;

    typedef struct packed {
        t_num [LANES-1:0] num;
        t_den [LANES-1:0] den;
    } t_div_req;

    // Clamp a signed raw channel to 0..FULL.
    function automatic t_chan clamp_chan(input t_raw x);
        logic [IW+CB-1:0] ext;
        t_chan            res;
        ext = {{CB{1'b0}}, x};
        if (x[IW-1]) begin
            res = '0;
        end else if (ext > {{IW{1'b0}}, FULL}) begin
            res = FULL;
        end else begin
            res = ext[CB-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/aob_front.sv
module aob_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  aob_pkg::t_raw [aob_pkg::LANES-1:0]  i_src,
    input  aob_pkg::t_raw [aob_pkg::LANES-1:0]  i_dst,
    output logic                                o_valid,
    input  logic                                i_ready,
    output aob_pkg::t_div_req                   o_req
);
    import aob_pkg::*;

    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    // Stage A: clamped pixels
    t_chan [LANES-1:0] r_a_s, r_a_d;
    // Stage B: first products
    t_chan [LANES-1:0] r_b_s, r_b_d;
    t_chan             r_b_inv;
    t_prod             r_b_pda;
    t_prod [2:0]       r_b_ps, r_b_pd;
    logic              r_b_opq, r_b_clr;
    // Stage C: weighted terms and coverage
    t_chan [LANES-1:0] r_c_s, r_c_d;
    t_prod             r_c_cov;
    t_wide [2:0]       r_c_ns, r_c_nd;
    logic              r_c_opq, r_c_clr;
    // Stage D: divider operands
    t_div_req          r_d_req;
    t_div_req          n_d_req;
    logic [LANES-1:0]  w_fit;

    assign w_rdy_d = !r_vld_d || i_ready;
    assign w_rdy_c = !r_vld_c || w_rdy_d;
    assign w_rdy_b = !r_vld_b || w_rdy_c;
    assign w_rdy_a = !r_vld_a || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vld_d;
    assign o_req   = r_d_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (w_rdy_a) r_vld_a <= i_valid;
            if (w_rdy_b) r_vld_b <= r_vld_a;
            if (w_rdy_c) r_vld_c <= r_vld_b;
            if (w_rdy_d) r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            for (int l = 0; l < LANES; l++) begin
                r_a_s[l] <= clamp_chan(i_src[l]);
                r_a_d[l] <= clamp_chan(i_dst[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_vld_a) begin
            r_b_s   <= r_a_s;
            r_b_d   <= r_a_d;
            r_b_inv <= FULL - r_a_s[LANE_ALPHA];
            r_b_pda <= t_prod'(r_a_d[LANE_ALPHA]) * t_prod'(FULL - r_a_s[LANE_ALPHA]);
            for (int l = 0; l < 3; l++) begin
                r_b_ps[l] <= t_prod'(r_a_s[l]) * t_prod'(r_a_s[LANE_ALPHA]);
                r_b_pd[l] <= t_prod'(r_a_d[l]) * t_prod'(r_a_d[LANE_ALPHA]);
            end
            r_b_opq <= (r_a_s[LANE_ALPHA] == FULL);
            r_b_clr <= (r_a_s[LANE_ALPHA] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_vld_b) begin
            r_c_s   <= r_b_s;
            r_c_d   <= r_b_d;
            r_c_cov <= t_prod'(r_b_s[LANE_ALPHA]) * t_prod'(FULL) + r_b_pda;
            for (int l = 0; l < 3; l++) begin
                r_c_ns[l] <= t_wide'(r_b_ps[l]) * t_wide'(FULL);
                r_c_nd[l] <= t_wide'(r_b_pd[l]) * t_wide'(r_b_inv);
            end
            r_c_opq <= r_b_opq;
            r_c_clr <= r_b_clr;
        end
    end

    // Rounded division is floor((2n + d) / 2d); a bypass lane uses (2v + 1) / 2.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_d_req.num[l] = ((t_num'(r_c_ns[l]) + t_num'(r_c_nd[l])) << 1)
                             + t_num'(r_c_cov);
            n_d_req.den[l] = {r_c_cov, 1'b0};
        end
        n_d_req.num[LANE_ALPHA] = t_num'({r_c_cov, 1'b0}) + t_num'(FULL);
        n_d_req.den[LANE_ALPHA] = t_den'({FULL, 1'b0});
        for (int l = 0; l < LANES; l++) begin
            if (r_c_opq) begin
                n_d_req.num[l] = t_num'({r_c_s[l], 1'b1});
                n_d_req.den[l] = t_den'(2);
            end else if (r_c_clr) begin
                n_d_req.num[l] = t_num'({r_c_d[l], 1'b1});
                n_d_req.den[l] = t_den'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_d && r_vld_c) begin
            r_d_req <= n_d_req;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_fit[l] = (r_d_req.den[l] != '0)
                    && (r_d_req.num[l] < (t_num'(r_d_req.den[l]) << CB));
        end
    end

    // Every quotient handed to the divider fits in one channel.
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_d |-> (w_fit == '1))
        else $error("divider operands give a quotient beyond full scale");

endmodule

### rtl/core/aob_divider.sv
module aob_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  aob_pkg::t_div_req                   i_req,
    output logic                                o_valid,
    input  logic                                i_ready,
    output aob_pkg::t_chan [aob_pkg::LANES-1:0] o_quot
);
    import aob_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    logic                r_vld [DIV_STAGES];
    t_num  [LANES-1:0]   r_rem [DIV_STAGES];
    t_den  [LANES-1:0]   r_den [DIV_STAGES];
    t_chan [LANES-1:0]   r_quo [DIV_STAGES];
    logic                w_rdy [DIV_STAGES+1];

    assign w_rdy[DIV_STAGES] = i_ready;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            logic              w_src_vld;
            t_num  [LANES-1:0] w_src_rem;
            t_den  [LANES-1:0] w_src_den;
            t_chan [LANES-1:0] w_src_quo;
            t_num  [LANES-1:0] n_rem;
            t_chan [LANES-1:0] n_quo;

            if (g == 0) begin : g_head
                assign w_src_vld = i_valid;
                assign w_src_rem = i_req.num;
                assign w_src_den = i_req.den;
                assign w_src_quo = '0;
            end else begin : g_body
                assign w_src_vld = r_vld[g-1];
                assign w_src_rem = r_rem[g-1];
                assign w_src_den = r_den[g-1];
                assign w_src_quo = r_quo[g-1];
            end

            assign w_rdy[g] = !r_vld[g] || w_rdy[g+1];

            // Restoring steps, most significant quotient bit first.
            always_comb begin
                int   k;
                t_num sh;
                n_rem = w_src_rem;
                n_quo = w_src_quo;
                for (int l = 0; l < LANES; l++) begin
                    for (int j = 0; j < BPS; j++) begin
                        k  = CB - 1 - (g * BPS + j);
                        sh = '0;
                        if (k >= 0) begin
                            sh = t_num'(w_src_den[l]) << k;
                            if (n_rem[l] >= sh) begin
                                n_rem[l] = n_rem[l] - sh;
                                n_quo[l][k[QIW-1:0]] = 1'b1;
                            end
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (w_rdy[g]) begin
                    r_vld[g] <= w_src_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[g] && w_src_vld) begin
                    r_rem[g] <= n_rem;
                    r_den[g] <= w_src_den;
                    r_quo[g] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[LAST];
    assign o_quot  = r_quo[LAST];

    // A finished division leaves a remainder below the divisor in every lane.
    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |-> (r_rem[LAST][0] < t_num'(r_den[LAST][0]))
                     && (r_rem[LAST][1] < t_num'(r_den[LAST][1]))
                     && (r_rem[LAST][2] < t_num'(r_den[LAST][2]))
                     && (r_rem[LAST][3] < t_num'(r_den[LAST][3])))
        else $error("division left a remainder not below the divisor");

    // An accepted request never carries a zero divisor.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> (i_req.den[0] != '0) && (i_req.den[1] != '0)
                              && (i_req.den[2] != '0) && (i_req.den[3] != '0))
        else $error("zero divisor entered the divider");

    // The first stage holds its work while the next stage is blocked.
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !w_rdy[1]) |=> (r_vld[0] && $stable(r_rem[0]) && $stable(r_quo[0])))
        else $error("divider head stage lost work during a stall");

endmodule

### rtl/core/alpha_over_blend.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+----------------------------------
// request   | in        | i_in_valid / o_in_ready    | i_src_* , i_dst_* (10-bit signed)
// result    | out       | o_out_valid / i_out_ready  | o_out_* (CB-bit unsigned)
//
// Throughput: one request per clock while the result side keeps taking results.
// Pipeline: four front arithmetic stages, then the divider at BPS quotient bits per
// lane per stage.
// Reset: synchronous, active low; clears only the stage valid bits.
// Stalls: each stage holds while the one after it is full and blocked; empty
// stages still fill, so bubbles close up and nothing is dropped or repeated.
module alpha_over_blend (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  aob_pkg::t_raw          i_src_red,
    input  aob_pkg::t_raw          i_src_green,
    input  aob_pkg::t_raw          i_src_blue,
    input  aob_pkg::t_raw          i_src_alpha,
    input  aob_pkg::t_raw          i_dst_red,
    input  aob_pkg::t_raw          i_dst_green,
    input  aob_pkg::t_raw          i_dst_blue,
    input  aob_pkg::t_raw          i_dst_alpha,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output aob_pkg::t_chan         o_out_red,
    output aob_pkg::t_chan         o_out_green,
    output aob_pkg::t_chan         o_out_blue,
    output aob_pkg::t_chan         o_out_alpha
);
    import aob_pkg::*;

    t_raw  [LANES-1:0] w_src, w_dst;
    t_div_req          w_req;
    logic              w_req_valid;
    logic              w_req_ready;
    t_chan [LANES-1:0] w_quot;

    // Gather the request fields into lanes: red, green, blue, alpha.
    assign w_src[LANE_RED]   = i_src_red;
    assign w_src[LANE_GREEN] = i_src_green;
    assign w_src[LANE_BLUE]  = i_src_blue;
    assign w_src[LANE_ALPHA] = i_src_alpha;
    assign w_dst[LANE_RED]   = i_dst_red;
    assign w_dst[LANE_GREEN] = i_dst_green;
    assign w_dst[LANE_BLUE]  = i_dst_blue;
    assign w_dst[LANE_ALPHA] = i_dst_alpha;

    // Front: clamp, products, coverage D = sa*M + da*(M - sa), and the
    // rounded-division operands. Opaque and transparent sources turn into
    // trivial divisions that return the clamped channel unchanged.
    aob_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_src   (w_src),
        .i_dst   (w_dst),
        .o_valid (w_req_valid),
        .i_ready (w_req_ready),
        .o_req   (w_req)
    );

    // Divider: four lanes of pipelined restoring division; for a blended pixel the colour lanes
    // divide by 2D, the alpha lane by 2M.
    aob_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_req_valid),
        .o_ready (w_req_ready),
        .i_req   (w_req),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_quot  (w_quot)
    );

    // The last divider stage is the output register.
    assign o_out_red   = w_quot[LANE_RED];
    assign o_out_green = w_quot[LANE_GREEN];
    assign o_out_blue  = w_quot[LANE_BLUE];
    assign o_out_alpha = w_quot[LANE_ALPHA];

endmodule

### sim/tb_alpha_over_blend.sv
`timescale 1ns / 100ps

// Testbench for alpha_over_blend: a stream of source/destination RGBA pixel
// pairs goes in, one "over" composite comes out per request. An in-bench
// predictor works out each composite when the request is taken. The checker
// compares every output pixel, lane by lane, with the oldest pending prediction.
module tb_alpha_over_blend;
    import aob_pkg::*;

    // Pipeline depth: the front stages plus the divider stages.
    localparam int BLOCK_LATENCY   = 4 + DIV_STAGES;
    // Longest legal stretch without a handshake is the long output hold
    // plus its drain. Allow a wide margin.
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_CYCLES     = 300;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        t_raw [LANES-1:0] src;
        t_raw [LANES-1:0] dst;
    } t_pixel_pair;

    typedef struct packed {
        t_chan [LANES-1:0] lane;
    } t_blend;

    // Clock and block inputs start at known values.
    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  i_out_ready = 1'b0;
    t_raw  i_src_red   = '0;
    t_raw  i_src_green = '0;
    t_raw  i_src_blue  = '0;
    t_raw  i_src_alpha = '0;
    t_raw  i_dst_red   = '0;
    t_raw  i_dst_green = '0;
    t_raw  i_dst_blue  = '0;
    t_raw  i_dst_alpha = '0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_chan o_out_red;
    t_chan o_out_green;
    t_chan o_out_blue;
    t_chan o_out_alpha;

    // Predicted composites, oldest first.
    t_blend expected_blends [$];

    string lane_names [LANES] = '{"red", "green", "blue", "alpha"};

    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned out_stall_pct  = 0;
    int unsigned hold_request   = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned in_stall_count = 0;
    int unsigned opaque_count   = 0;
    int unsigned clear_count    = 0;
    int unsigned mixed_count    = 0;

    always #4 i_clk = ~i_clk;

    alpha_over_blend DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_src_red   (i_src_red),
        .i_src_green (i_src_green),
        .i_src_blue  (i_src_blue),
        .i_src_alpha (i_src_alpha),
        .i_dst_red   (i_dst_red),
        .i_dst_green (i_dst_green),
        .i_dst_blue  (i_dst_blue),
        .i_dst_alpha (i_dst_alpha),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp a raw signed channel to 0..full scale.
    function automatic longint clamp_channel(input t_raw x);
        longint v;
        v = longint'(x);
        if (v < 0) begin
            v = 0;
        end else if (v > longint'(FULL)) begin
            v = longint'(FULL);
        end
        return v;
    endfunction

    // Divide rounding halves up, then saturate at full scale.
    function automatic t_chan round_div_sat(input longint n, input longint d);
        longint q;
        q = (2 * n + d) / (2 * d);
        if (q > longint'(FULL)) begin
            q = longint'(FULL);
        end
        return t_chan'(q);
    endfunction

    // Non-premultiplied over composite of one pixel pair.
    function automatic t_blend blend_over(input t_pixel_pair px);
        longint s [LANES];
        longint d [LANES];
        longint full_l, inv, den;
        t_blend r;
        full_l = longint'(FULL);
        for (int l = 0; l < LANES; l++) begin
            s[l] = clamp_channel(px.src[l]);
            d[l] = clamp_channel(px.dst[l]);
        end
        if (s[LANE_ALPHA] == full_l) begin
            // Opaque source wins outright.
            for (int l = 0; l < LANES; l++) r.lane[l] = t_chan'(s[l]);
        end else if (s[LANE_ALPHA] == 0) begin
            // Transparent source leaves the destination untouched.
            for (int l = 0; l < LANES; l++) r.lane[l] = t_chan'(d[l]);
        end else begin
            inv = full_l - s[LANE_ALPHA];
            // den is the output alpha times full scale, kept exact.
            den = s[LANE_ALPHA] * full_l + d[LANE_ALPHA] * inv;
            for (int l = 0; l < LANE_ALPHA; l++) begin
                r.lane[l] = round_div_sat(s[l] * s[LANE_ALPHA] * full_l
                                          + d[l] * d[LANE_ALPHA] * inv, den);
            end
            r.lane[LANE_ALPHA] = round_div_sat(den, full_l);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_pixel_pair make_pixel(input int sr, input int sg, input int sb,
                                               input int sa, input int dr, input int dg,
                                               input int db, input int da);
        t_pixel_pair px;
        px.src[LANE_RED]   = t_raw'(sr);
        px.src[LANE_GREEN] = t_raw'(sg);
        px.src[LANE_BLUE]  = t_raw'(sb);
        px.src[LANE_ALPHA] = t_raw'(sa);
        px.dst[LANE_RED]   = t_raw'(dr);
        px.dst[LANE_GREEN] = t_raw'(dg);
        px.dst[LANE_BLUE]  = t_raw'(db);
        px.dst[LANE_ALPHA] = t_raw'(da);
        return px;
    endfunction

    // Mix of the range -256..511, the nominal range 0..255 and the clamp edges.
    function automatic t_raw rand_channel();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(767)) - 256;
            1: begin
                case ($urandom_range(7))
                    0: v = -256;
                    1: v = -1;
                    2: v = 0;
                    3: v = 1;
                    4: v = 254;
                    5: v = 255;
                    6: v = 256;
                    default: v = 511;
                endcase
            end
            default: v = int'($urandom_range(255));
        endcase
        return t_raw'(v);
    endfunction

    // Weight source alpha toward the blend path, where most of the math lives.
    function automatic t_raw rand_src_alpha();
        t_raw a;
        if ($urandom_range(9) < 6) begin
            a = t_raw'($urandom_range(254, 1));
        end else begin
            a = rand_channel();
        end
        return a;
    endfunction

    function automatic t_pixel_pair rand_pixel();
        t_pixel_pair px;
        for (int l = 0; l < LANES; l++) begin
            px.src[l] = rand_channel();
            px.dst[l] = rand_channel();
        end
        px.src[LANE_ALPHA] = rand_src_alpha();
        return px;
    endfunction

    task automatic drive_payload(input t_pixel_pair px);
        i_src_red   <= px.src[LANE_RED];
        i_src_green <= px.src[LANE_GREEN];
        i_src_blue  <= px.src[LANE_BLUE];
        i_src_alpha <= px.src[LANE_ALPHA];
        i_dst_red   <= px.dst[LANE_RED];
        i_dst_green <= px.dst[LANE_GREEN];
        i_dst_blue  <= px.dst[LANE_BLUE];
        i_dst_alpha <= px.dst[LANE_ALPHA];
    endtask

    // Offer one request, hold it until taken, predict its composite, then
    // idle at random. Called right after a rising edge.
    task automatic send_pixel(input t_pixel_pair px);
        longint sa;
        int unsigned gap;
        i_in_valid <= 1'b1;
        drive_payload(px);
        do @(posedge i_clk); while (!o_in_ready);
        expected_blends.push_back(blend_over(px));
        sa = clamp_channel(px.src[LANE_ALPHA]);
        if (sa == longint'(FULL)) opaque_count++;
        else if (sa == 0) clear_count++;
        else mixed_count++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            // Drop valid and scramble the payload: it must be ignored.
            i_in_valid <= 1'b0;
            drive_payload(rand_pixel());
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lower valid, let every pending result come out, then let the pipe settle.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_blends.size() != 0) @(posedge i_clk);
        repeat (BLOCK_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hit the clamp edges, both shortcut paths and the blend extremes.
    task automatic test_directed_corners();
        send_idle_pct = 0;
        out_stall_pct = 0;
        // All channels far negative: transparent source, black destination.
        send_pixel(make_pixel(-256, -256, -256, -256, -256, -256, -256, -256));
        // All channels at the top of the field: opaque, clamped to full scale.
        send_pixel(make_pixel(511, 511, 511, 511, 511, 511, 511, 511));
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255));
        // Opaque and transparent source over the same destination.
        send_pixel(make_pixel(10, 20, 30, 255, 200, 100, 50, 128));
        send_pixel(make_pixel(10, 20, 30, 0, 200, 100, 50, 128));
        // Negative alpha acts as transparent; destination still clamps.
        send_pixel(make_pixel(99, 99, 99, -1, -5, 300, 77, 511));
        // Alpha past full scale acts as opaque; source still clamps.
        send_pixel(make_pixel(-3, 400, 128, 300, 1, 2, 3, 4));
        send_pixel(make_pixel(7, 8, 9, 256, 1, 2, 3, 4));
        // Blend path at its alpha extremes.
        send_pixel(make_pixel(255, 0, 128, 1, 0, 255, 64, 255));
        send_pixel(make_pixel(255, 0, 128, 254, 0, 255, 64, 0));
        send_pixel(make_pixel(13, 200, 77, 1, 90, 90, 90, 0));
        send_pixel(make_pixel(40, 150, 250, 128, 250, 150, 40, 0));
        send_pixel(make_pixel(40, 150, 250, 128, 250, 150, 40, 255));
        send_pixel(make_pixel(255, 0, 255, 127, 0, 255, 0, 1));
        // Blend with out-of-range colour on both sides.
        send_pixel(make_pixel(-100, -1, 511, 64, 300, 256, -256, 192));
        send_pixel(make_pixel(255, 255, 255, 254, 255, 255, 255, 255));
        wait_drain();
    endtask

    task automatic test_random_blends(input int count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        repeat (count) send_pixel(rand_pixel());
        wait_drain();
    endtask

    // Hold the output off for a long stretch while requests keep coming,
    // so the pipe fills and the input must stall.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (60) send_pixel(rand_pixel());
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Output side: ready, checker, watchdog
    // ------------------------------------------------------------------

    // Count the long hold here; otherwise stall at the phase's rate.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Compare each taken result with the oldest prediction.
    t_blend got_blend;
    t_blend want_blend;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_blend.lane[LANE_RED]   = o_out_red;
            got_blend.lane[LANE_GREEN] = o_out_green;
            got_blend.lane[LANE_BLUE]  = o_out_blue;
            got_blend.lane[LANE_ALPHA] = o_out_alpha;
            if (expected_blends.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: %h", got_blend));
            end else begin
                want_blend = expected_blends.pop_front();
                for (int l = 0; l < LANES; l++) begin
                    if (got_blend.lane[l] !== want_blend.lane[l]) begin
                        report_mismatch($sformatf("%s got %0d, want %0d", lane_names[l],
                                                  got_blend.lane[l], want_blend.lane[l]));
                    end
                end
            end
        end
    end

    // Count input stalls; advance the quiet counter on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_ready) in_stall_count++;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
                     $realtime, quiet_cycles, expected_blends.size());
            $display("alpha_over_blend verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_blends(200, 0, 0);
        test_random_blends(200, 76, 0);
        test_random_blends(200, 0, 76);
        test_random_blends(200, 37, 37);
        test_output_backpressure();

        if (expected_blends.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_blends.size()));
        end
        $display("Sent %0d pixel pairs: %0d opaque, %0d transparent, %0d blended source.",
                 opaque_count + clear_count + mixed_count, opaque_count, clear_count,
                 mixed_count);
        $display("Input stalled %0d cycles under output backpressure; %0d mismatches.",
                 in_stall_count, error_count);
        if (error_count == 0) begin
            $display("alpha_over_blend verification clean");
        end else begin
            $display("alpha_over_blend verification failed");
        end
        $finish;
    end

endmodule
